// ===== rtl/fob_pkg.sv =====
// Shared types and constants for the feathered overlap blend core.
`timescale 1ns / 1ps
`default_nettype none
package fob_pkg;

  localparam int DIM_W      = 13;
  localparam int OFS_W      = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OVERLAP_WIDTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REF_WIDTH     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_REF_HEIGHT    = 3'd6;

  // Pixel classes decided by the front end
  localparam logic [1:0] CLS_PASS    = 2'd0;
  localparam logic [1:0] CLS_SUM     = 2'd1;
  localparam logic [1:0] CLS_REF     = 2'd2;
  localparam logic [1:0] CLS_FEATHER = 2'd3;

  typedef struct packed {
    logic [7:0] base_red;
    logic [7:0] base_green;
    logic [7:0] base_blue;
    logic [7:0] ref_red;
    logic [7:0] ref_green;
    logic [7:0] ref_blue;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       frame_end;
  } pixel_out_t;

  typedef struct packed {
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
    logic [DIM_W-1:0] overlap_width;
    logic [OFS_W-1:0] offset_x;
    logic [OFS_W-1:0] offset_y;
    logic [DIM_W-1:0] ref_width;
    logic [DIM_W-1:0] ref_height;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       cls;
    logic [DIM_W-1:0] x;
    logic [DIM_W-1:0] w;
    pixel_in_t        pix;
    logic             frame_end;
  } job_t;

endpackage
`default_nettype wire

// ===== rtl/fob_queue.sv =====
// Two-entry job queue between the front end and the blend engine.
`timescale 1ns / 1ps
`default_nettype none
module fob_queue (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire fob_pkg::job_t wdata,
  output logic             full,
  input  wire logic        pop,
  output fob_pkg::job_t    rdata,
  output logic             empty
);

  fob_pkg::job_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/fob_front.sv =====
// Front end: raster position counters and per-pixel classification.
`timescale 1ns / 1ps
`default_nettype none
module fob_front #(
  parameter int MAX_DIM = 4096
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire fob_pkg::cfg_t     cfg,
  input  wire logic              push,
  input  wire fob_pkg::pixel_in_t din,
  input  wire logic              q_full,
  output logic                   q_push,
  output fob_pkg::job_t          q_job
);

  localparam int CW = $clog2(MAX_DIM);
  localparam int EW = ((CW > fob_pkg::DIM_W) ? CW : fob_pkg::DIM_W) + 2;

  logic [CW-1:0] column_count;
  logic [CW-1:0] row_count;
  logic [EW-1:0] effw;
  logic [EW-1:0] effh;
  logic [EW-1:0] dx;
  logic [EW-1:0] dy;
  logic          last_col;
  logic          last_row;
  logic          in_rect;
  logic          strip;
  logic          black;

  always_comb begin
    if (cfg.image_width == '0) begin
      effw = EW'(1);
    end else if (EW'(cfg.image_width) > EW'(MAX_DIM)) begin
      effw = EW'(MAX_DIM);
    end else begin
      effw = EW'(cfg.image_width);
    end
    if (cfg.image_height == '0) begin
      effh = EW'(1);
    end else if (EW'(cfg.image_height) > EW'(MAX_DIM)) begin
      effh = EW'(MAX_DIM);
    end else begin
      effh = EW'(cfg.image_height);
    end
  end

  assign last_col = (EW'(column_count) + EW'(1)) >= effw;
  assign last_row = (EW'(row_count) + EW'(1)) >= effh;

  assign dx = EW'(column_count) - EW'(cfg.offset_x);
  assign dy = EW'(row_count) - EW'(cfg.offset_y);

  assign in_rect = (EW'(column_count) >= EW'(cfg.offset_x)) && (dx < EW'(cfg.ref_width)) &&
                   (EW'(row_count) >= EW'(cfg.offset_y)) && (dy < EW'(cfg.ref_height));
  assign strip  = dx < EW'(cfg.overlap_width);
  assign black  = (din.base_red == 8'd0) && (din.base_green == 8'd0) &&
                  (din.base_blue == 8'd0);

  assign q_push = push && !q_full;

  always_comb begin
    q_job.x         = dx[fob_pkg::DIM_W-1:0];
    q_job.w         = cfg.overlap_width;
    q_job.pix       = din;
    q_job.frame_end = last_col && last_row;
    if (!in_rect) begin
      q_job.cls = fob_pkg::CLS_PASS;
    end else if (strip && black) begin
      q_job.cls = fob_pkg::CLS_REF;
    end else if (strip) begin
      q_job.cls = fob_pkg::CLS_FEATHER;
    end else begin
      q_job.cls = fob_pkg::CLS_SUM;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (q_push) begin
      if (last_col) begin
        column_count <= '0;
        row_count    <= last_row ? '0 : row_count + CW'(1);
      end else begin
        column_count <= column_count + CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/fob_back.sv =====
// Blend engine: bit-serial weight divider, weighting multipliers, result register.
`timescale 1ns / 1ps
`default_nettype none
module fob_back #(
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_empty,
  input  wire fob_pkg::job_t  q_job,
  output logic                q_pop,
  input  wire logic           pop,
  output logic                empty,
  output fob_pkg::pixel_out_t dout
);

  localparam int F    = WEIGHT_FRAC_BITS;
  localparam int QW   = F + 1;
  localparam int NW   = F + fob_pkg::DIM_W + 1;
  localparam int RW   = fob_pkg::DIM_W + 1;
  localparam int CNTW = $clog2(NW + 1);
  localparam int PW   = F + 9;
  localparam logic [PW-1:0] ROUND = {{(PW - F){1'b0}}, 1'b1, {(F - 1){1'b0}}};

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_MUL  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]          state;
  fob_pkg::job_t       job;
  logic [NW-1:0]       num_b;
  logic [NW-1:0]       num_r;
  logic [RW-1:0]       rem_b;
  logic [RW-1:0]       rem_r;
  logic [QW-1:0]       quo_b;
  logic [QW-1:0]       quo_r;
  logic [CNTW-1:0]     cnt;
  logic [PW-1:0]       prod_b [3];
  logic [PW-1:0]       prod_r [3];
  logic                out_valid;
  fob_pkg::pixel_out_t out_data;
  fob_pkg::pixel_out_t result;

  logic [RW-1:0]       sh_b;
  logic [RW-1:0]       sh_r;
  logic                ge_b;
  logic                ge_r;
  logic                load;
  logic [7:0]          base_ch [3];
  logic [7:0]          ref_ch [3];
  logic [7:0]          res_ch [3];
  logic [fob_pkg::DIM_W-1:0] w_minus_x;

  function automatic logic [7:0] sat8(input logic [9:0] v);
    logic [7:0] r;
    r = (v > 10'd255) ? 8'hFF : v[7:0];
    return r;
  endfunction

  assign q_pop = (state == S_IDLE) && !q_empty;
  assign empty = !out_valid;
  assign dout  = out_data;
  assign load  = (state == S_DONE) && (!out_valid || pop);

  assign w_minus_x = q_job.w - q_job.x;

  assign sh_b = {rem_b[RW-2:0], num_b[NW-1]};
  assign sh_r = {rem_r[RW-2:0], num_r[NW-1]};
  assign ge_b = sh_b >= RW'(job.w);
  assign ge_r = sh_r >= RW'(job.w);

  assign base_ch[0] = job.pix.base_red;
  assign base_ch[1] = job.pix.base_green;
  assign base_ch[2] = job.pix.base_blue;
  assign ref_ch[0]  = job.pix.ref_red;
  assign ref_ch[1]  = job.pix.ref_green;
  assign ref_ch[2]  = job.pix.ref_blue;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      case (job.cls)
        fob_pkg::CLS_PASS:    res_ch[i] = base_ch[i];
        fob_pkg::CLS_REF:     res_ch[i] = ref_ch[i];
        fob_pkg::CLS_SUM:     res_ch[i] = sat8(10'(base_ch[i]) + 10'(ref_ch[i]));
        fob_pkg::CLS_FEATHER: res_ch[i] = sat8(10'(sat8(10'(prod_b[i][PW-1:F]))) +
                                               10'(prod_r[i][PW-1:F]));
        default:              res_ch[i] = base_ch[i];
      endcase
    end
    result.out_red   = res_ch[0];
    result.out_green = res_ch[1];
    result.out_blue  = res_ch[2];
    result.frame_end = job.frame_end;
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (!q_empty) begin
          job   <= q_job;
          num_b <= (NW'(w_minus_x) << F) + NW'(q_job.w >> 1);
          num_r <= (NW'(q_job.x) << F) + NW'(q_job.w >> 1);
          rem_b <= '0;
          rem_r <= '0;
          quo_b <= '0;
          quo_r <= '0;
          cnt   <= CNTW'(NW);
        end
      end
      S_DIV: begin
        num_b <= num_b << 1;
        num_r <= num_r << 1;
        rem_b <= ge_b ? sh_b - RW'(job.w) : sh_b;
        rem_r <= ge_r ? sh_r - RW'(job.w) : sh_r;
        quo_b <= {quo_b[QW-2:0], ge_b};
        quo_r <= {quo_r[QW-2:0], ge_r};
        cnt   <= cnt - CNTW'(1);
      end
      S_MUL: begin
        for (int i = 0; i < 3; i++) begin
          prod_b[i] <= PW'(base_ch[i]) * PW'(quo_b) + ROUND;
          prod_r[i] <= PW'(ref_ch[i]) * PW'(quo_r) + ROUND;
        end
      end
      default: begin
      end
    endcase
    if (load) begin
      out_data <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            state <= (q_job.cls == fob_pkg::CLS_FEATHER) ? S_DIV : S_DONE;
          end
        end
        S_DIV: begin
          if (cnt == CNTW'(1)) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/feathered_overlap_blend_core.sv =====
// Top level: configuration registers, front end, job queue and blend engine.
//
//   channel   direction  handshake          payload
//   pixels    in         push / full        din  (fob_pkg::pixel_in_t)
//   results   out        pop / empty        dout (fob_pkg::pixel_out_t)
//   config    in         cfg_valid / ready  cfg_index, cfg_data
//
// A pixel outside the reference rectangle or the feather strip, or with a black base,
// skips the divider in the blend engine; a feathered pixel passes through the bit-serial
// divider that forms both weights, then through the weighting multipliers.
// The front end classifies at input rate into a two-entry queue; a waiting
// result does not stop the engine until its next result is ready.
// rst clears counters, queue, engine and the registers to their defaults.
`timescale 1ns / 1ps
`default_nettype none
module feathered_overlap_blend_core #(
  parameter int MAX_DIM          = 4096,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              push,
  output logic                                   full,
  input  wire fob_pkg::pixel_in_t                din,
  input  wire logic                              pop,
  output logic                                   empty,
  output fob_pkg::pixel_out_t                    dout,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [fob_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [fob_pkg::CFG_DATA_W-1:0]    cfg_data
);

  fob_pkg::cfg_t cfg;
  fob_pkg::job_t f_job;
  fob_pkg::job_t q_job;
  logic          f_push;
  logic          q_full;
  logic          q_empty;
  logic          q_pop;

  assign cfg_ready = 1'b1;
  assign full      = q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width   <= 13'd640;
      cfg.image_height  <= 13'd480;
      cfg.overlap_width <= 13'd1;
      cfg.offset_x      <= 12'd0;
      cfg.offset_y      <= 12'd0;
      cfg.ref_width     <= 13'd1;
      cfg.ref_height    <= 13'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fob_pkg::REG_IMAGE_WIDTH:   cfg.image_width   <= cfg_data;
        fob_pkg::REG_IMAGE_HEIGHT:  cfg.image_height  <= cfg_data;
        fob_pkg::REG_OVERLAP_WIDTH: cfg.overlap_width <= cfg_data;
        fob_pkg::REG_OFFSET_X:      cfg.offset_x      <= cfg_data[fob_pkg::OFS_W-1:0];
        fob_pkg::REG_OFFSET_Y:      cfg.offset_y      <= cfg_data[fob_pkg::OFS_W-1:0];
        fob_pkg::REG_REF_WIDTH:     cfg.ref_width     <= cfg_data;
        fob_pkg::REG_REF_HEIGHT:    cfg.ref_height    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  fob_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .push   (push),
    .din    (din),
    .q_full (q_full),
    .q_push (f_push),
    .q_job  (f_job)
  );

  fob_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .wdata (f_job),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_job),
    .empty (q_empty)
  );

  fob_back #(
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_job   (q_job),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .dout    (dout)
  );

endmodule
`default_nettype wire
